/* design/button_and_auto_dimming_control_assert.svh */
// Assertion macros shared by the button and auto dimming control modules.
`ifndef BUTTON_AND_AUTO_DIMMING_CONTROL_ASSERT_SVH
`define BUTTON_AND_AUTO_DIMMING_CONTROL_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BADC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("badc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BADC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("badc: next-cycle check failed");

`endif

/* design/badc_pkg.sv */
// Shared types and constants of the button and auto dimming control.
package badc_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned FiltW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegShortPressMin  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPressCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinBrightness  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DataW-1:0] ShortPressMinRst  = 8'd5;
  localparam logic [DataW-1:0] LongPressCountRst = 8'd200;
  localparam logic [DataW-1:0] MinBrightnessRst  = 8'd30;

  // Top of the 8-bit range, used for saturation, clamping and inversion.
  localparam logic [DataW-1:0] DutyMax = 8'd255;

  // Right shift applied to the light by knob product in auto mode.
  localparam int unsigned ProdShift = 7;

  typedef struct packed {
    logic [DataW-1:0] short_press_min;
    logic [DataW-1:0] long_press_count;
    logic [DataW-1:0] min_brightness;
  } badc_cfg_t;

  // Mode flags after a tick, passed from the button logic to the duty path.
  typedef struct packed {
    logic backlight_on;
    logic auto_on;
    logic auto_toggled;
  } badc_flags_t;

endpackage

/* design/badc_press.sv */
// Button press counter with the backlight and auto dimming toggles.
`include "button_and_auto_dimming_control_assert.svh"

module badc_press (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   held_i,
  input  badc_pkg::badc_cfg_t    cfg_i,
  output badc_pkg::badc_flags_t  flags_o
);

  logic [badc_pkg::DataW-1:0] press_count_q, press_count_d;
  logic                       backlight_q, backlight_d;
  logic                       auto_q, auto_d;
  logic                       short_press;
  logic                       long_press;

  // A release inside the short window toggles the backlight; hitting the long
  // count toggles auto dimming whatever the button level.
  always_comb begin
    short_press = !held_i && (press_count_q >= cfg_i.short_press_min) &&
                  (press_count_q < cfg_i.long_press_count);
    long_press  = (press_count_q == cfg_i.long_press_count);
    backlight_d = backlight_q ^ short_press;
    auto_d      = auto_q ^ long_press;
    if (!held_i) begin
      press_count_d = '0;
    end else if (press_count_q != badc_pkg::DutyMax) begin
      press_count_d = press_count_q + 8'd1;
    end else begin
      press_count_d = press_count_q;
    end
  end

  assign flags_o.backlight_on = backlight_d;
  assign flags_o.auto_on      = auto_d;
  assign flags_o.auto_toggled = long_press;

  // State moves only when a beat passes from the input to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_count_q <= '0;
      backlight_q   <= 1'b0;
      auto_q        <= 1'b0;
    end else if (adv_i) begin
      press_count_q <= press_count_d;
      backlight_q   <= backlight_d;
      auto_q        <= auto_d;
    end
  end

  `BADC_ASSERT_NEXT(a_hold_when_idle, clk_i, rst_ni, !adv_i,
                    $stable(press_count_q) && $stable(backlight_q) && $stable(auto_q))
  `BADC_ASSERT_IMP(a_backlight_on_release, clk_i, rst_ni, adv_i && (backlight_d != backlight_q),
                   !held_i)
  `BADC_ASSERT_NEXT(a_auto_only_on_long, clk_i, rst_ni, adv_i && !long_press,
                    auto_q == $past(auto_q))

endmodule

/* design/badc_duty.sv */
// Sample filters, dimming duty selection and output smoothing.
module badc_duty (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [badc_pkg::DataW-1:0]  knob_i,
  input  logic [badc_pkg::DataW-1:0]  light_i,
  input  logic [badc_pkg::DataW-1:0]  min_brightness_i,
  input  badc_pkg::badc_flags_t       flags_i,
  output logic [badc_pkg::DataW-1:0]  dimming_duty_o,
  output logic [badc_pkg::DataW-1:0]  backlight_compare_o
);

  logic [badc_pkg::FiltW-1:0] knob_filt_q, knob_filt_d;
  logic [badc_pkg::FiltW-1:0] light_filt_q, light_filt_d;
  logic [badc_pkg::FiltW-1:0] back_smooth_q, back_smooth_d;
  logic [badc_pkg::FiltW-1:0] dim_smooth_q, dim_smooth_d;
  logic [badc_pkg::DataW-1:0] knob_hi;
  logic [badc_pkg::DataW-1:0] light_hi;
  logic [2*badc_pkg::DataW-1:0] prod;
  logic [badc_pkg::DataW:0]   auto_raw;
  logic [badc_pkg::DataW-1:0] duty;
  logic [badc_pkg::DataW-1:0] back_duty;

  // First-order filters on the two samples.
  always_comb begin
    knob_filt_d  = knob_filt_q - (knob_filt_q >> 4) + {4'd0, knob_i, 4'd0};
    light_filt_d = light_filt_q - (light_filt_q >> 8) + {8'd0, light_i};
    knob_hi      = knob_filt_d[15:8];
    light_hi     = light_filt_d[15:8];
  end

  // Duty: scaled product clamped to the floor and full scale in auto mode,
  // the filtered knob with a floor in manual mode.
  always_comb begin
    prod     = light_hi * knob_hi;
    auto_raw = prod[15:badc_pkg::ProdShift];
    if (flags_i.auto_on) begin
      if (auto_raw < {1'b0, min_brightness_i}) begin
        duty = min_brightness_i;
      end else if (auto_raw > {1'b0, badc_pkg::DutyMax}) begin
        duty = badc_pkg::DutyMax;
      end else begin
        duty = auto_raw[7:0];
      end
    end else if (knob_hi < min_brightness_i) begin
      duty = min_brightness_i;
    end else begin
      duty = knob_hi;
    end
    back_duty = flags_i.backlight_on ? duty : '0;
  end

  // Output smoothers.
  always_comb begin
    back_smooth_d = back_smooth_q - (back_smooth_q >> 5) + {5'd0, back_duty, 3'd0};
    dim_smooth_d  = dim_smooth_q - (dim_smooth_q >> 5) + {5'd0, duty, 3'd0};
  end

  assign dimming_duty_o      = dim_smooth_d[15:8];
  assign backlight_compare_o = badc_pkg::DutyMax - back_smooth_d[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knob_filt_q   <= '0;
      light_filt_q  <= '0;
      back_smooth_q <= '0;
      dim_smooth_q  <= '0;
    end else if (adv_i) begin
      knob_filt_q   <= knob_filt_d;
      light_filt_q  <= light_filt_d;
      back_smooth_q <= back_smooth_d;
      dim_smooth_q  <= dim_smooth_d;
    end
  end

endmodule

/* design/button_and_auto_dimming_control.sv */
// Top level of the button and auto dimming control.
//
// Each input beat is one control tick: button level, knob sample and light
// sample. Every tick yields exactly one result beat with the smoothed dimming
// duty, the inverted backlight compare value and the mode flags.
// Beats pass an input register, then the filter and duty logic, then a result
// register. With no stall, an accepted beat is held in the input register and
// then loaded into the result register, where it is offered. One beat per
// cycle is sustained while out_stall_i stays low; the filter, product and
// smoother path is combinational between the two registers. When the receiver
// raises out_stall_i the result register holds its beat; the input register
// still takes one more beat, and in_stall_o rises only once both registers are
// full. Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while the block is idle, which
// the block does not enforce. An index beyond the last register is ignored.
// Reset clears the press counter, the flags, the filters and both smoothers,
// and loads the register defaults.
`include "button_and_auto_dimming_control_assert.svh"

module button_and_auto_dimming_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [badc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [badc_pkg::DataW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          button_pressed_i,
  input  logic [badc_pkg::DataW-1:0]    knob_sample_i,
  input  logic [badc_pkg::DataW-1:0]    light_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [badc_pkg::DataW-1:0]    dimming_duty_o,
  output logic [badc_pkg::DataW-1:0]    backlight_compare_o,
  output logic                          backlight_on_o,
  output logic                          auto_on_o,
  output logic                          auto_toggled_o
);

  badc_pkg::badc_cfg_t        cfg_q;
  logic                       in_valid_q;
  logic                       button_q;
  logic [badc_pkg::DataW-1:0] knob_q;
  logic [badc_pkg::DataW-1:0] light_q;
  logic                       out_valid_q;
  logic [badc_pkg::DataW-1:0] dimming_q;
  logic [badc_pkg::DataW-1:0] compare_q;
  badc_pkg::badc_flags_t      flags_q;
  badc_pkg::badc_flags_t      flags_d;
  logic [badc_pkg::DataW-1:0] dimming_d;
  logic [badc_pkg::DataW-1:0] compare_d;
  logic                       adv;
  logic                       in_accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_press_min  <= badc_pkg::ShortPressMinRst;
      cfg_q.long_press_count <= badc_pkg::LongPressCountRst;
      cfg_q.min_brightness   <= badc_pkg::MinBrightnessRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        badc_pkg::RegShortPressMin:  cfg_q.short_press_min  <= cfg_data_i;
        badc_pkg::RegLongPressCount: cfg_q.long_press_count <= cfg_data_i;
        badc_pkg::RegMinBrightness:  cfg_q.min_brightness   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A beat advances when the result register is empty or being drained.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      button_q <= button_pressed_i;
      knob_q   <= knob_sample_i;
      light_q  <= light_sample_i;
    end
  end

  badc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .held_i  (button_q),
    .cfg_i   (cfg_q),
    .flags_o (flags_d)
  );

  badc_duty u_duty (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .adv_i               (adv),
    .knob_i              (knob_q),
    .light_i             (light_q),
    .min_brightness_i    (cfg_q.min_brightness),
    .flags_i             (flags_d),
    .dimming_duty_o      (dimming_d),
    .backlight_compare_o (compare_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dimming_q <= dimming_d;
      compare_q <= compare_d;
      flags_q   <= flags_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign dimming_duty_o      = dimming_q;
  assign backlight_compare_o = compare_q;
  assign backlight_on_o      = flags_q.backlight_on;
  assign auto_on_o           = flags_q.auto_on;
  assign auto_toggled_o      = flags_q.auto_toggled;

  `BADC_ASSERT_IMP(a_stall_needs_beat, clk_i, rst_ni, in_stall_o,
                   in_valid_q && out_valid_q && out_stall_i)
  `BADC_ASSERT_NEXT(a_adv_fills_result, clk_i, rst_ni, adv, out_valid_q)

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the button and auto dimming control block.
module tb_top;
  import badc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  // Index 3 decodes to no register; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] duty;
    logic [DataW-1:0] bl_cmp;
    logic             bl_on;
    logic             auto_on;
    logic             auto_tgl;
  } dim_result_t;

  typedef struct packed {
    logic             btn;
    logic [DataW-1:0] knob;
    logic [DataW-1:0] light;
    logic             typed;
    dim_result_t      res;
  } tick_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DataW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               button_pressed_i = 1'b0;
  logic [DataW-1:0]   knob_sample_i = '0;
  logic [DataW-1:0]   light_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [DataW-1:0]   dimming_duty_o;
  logic [DataW-1:0]   backlight_compare_o;
  logic               backlight_on_o;
  logic               auto_on_o;
  logic               auto_toggled_o;

  // Shadow copy of the block's registers and state.
  badc_cfg_t          dim_cfg = '{ShortPressMinRst, LongPressCountRst, MinBrightnessRst};
  logic [DataW-1:0]   press_cnt = '0;
  logic               backlight_en = 1'b0;
  logic               auto_en = 1'b0;
  logic [FiltW-1:0]   knob_filt = '0;
  logic [FiltW-1:0]   light_filt = '0;
  logic [FiltW-1:0]   bl_smooth = '0;
  logic [FiltW-1:0]   dim_smooth = '0;

  dim_result_t        tick_results_q[$];
  dim_result_t        head_result;
  int unsigned        err_cnt = 0;
  int unsigned        cycle_cnt = 0;
  int unsigned        tx_idle_pct = 0;
  int unsigned        rx_stall_pct = 0;
  logic [DataW-1:0]   knob_lvl = '0;
  logic [DataW-1:0]   light_lvl = '0;

  // Directed ticks after reset. The first two results are typed in by hand.
  tick_row_t dir_rows [0:22] = '{
    '{1'b0, 8'd255, 8'd255, 1'b1, '{8'd0, 8'd255, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'd0,   8'd0,   1'b1, '{8'd1, 8'd255, 1'b0, 1'b0, 1'b0}},
    '{1'b1, 8'd255, 8'd0,   1'b0, '0},
    '{1'b1, 8'd255, 8'd0,   1'b0, '0},
    '{1'b1, 8'd255, 8'd0,   1'b0, '0},
    '{1'b1, 8'd255, 8'd0,   1'b0, '0},
    '{1'b1, 8'd255, 8'd0,   1'b0, '0},
    '{1'b0, 8'd255, 8'd0,   1'b0, '0},
    '{1'b1, 8'd0,   8'd255, 1'b0, '0},
    '{1'b1, 8'd0,   8'd255, 1'b0, '0},
    '{1'b1, 8'd0,   8'd255, 1'b0, '0},
    '{1'b1, 8'd0,   8'd255, 1'b0, '0},
    '{1'b0, 8'd0,   8'd255, 1'b0, '0},
    '{1'b1, 8'd128, 8'd128, 1'b0, '0},
    '{1'b1, 8'd128, 8'd128, 1'b0, '0},
    '{1'b1, 8'd128, 8'd128, 1'b0, '0},
    '{1'b1, 8'd128, 8'd128, 1'b0, '0},
    '{1'b1, 8'd128, 8'd128, 1'b0, '0},
    '{1'b0, 8'd128, 8'd128, 1'b0, '0},
    '{1'b1, 8'd255, 8'd255, 1'b0, '0},
    '{1'b0, 8'd255, 8'd255, 1'b0, '0},
    '{1'b0, 8'd255, 8'd0,   1'b0, '0},
    '{1'b0, 8'd0,   8'd255, 1'b0, '0}
  };

  button_and_auto_dimming_control i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .button_pressed_i    (button_pressed_i),
    .knob_sample_i       (knob_sample_i),
    .light_sample_i      (light_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .dimming_duty_o      (dimming_duty_o),
    .backlight_compare_o (backlight_compare_o),
    .backlight_on_o      (backlight_on_o),
    .auto_on_o           (auto_on_o),
    .auto_toggled_o      (auto_toggled_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One smoothing step: the accumulator loses 1/32 and gains eight times the value.
  function automatic logic [FiltW-1:0] smooth_step(logic [FiltW-1:0] acc, int unsigned val);
    int unsigned sum;
    sum = acc;
    sum = sum - (sum >> 5) + (val << 3);
    return sum[FiltW-1:0];
  endfunction

  // Advances the shadow state by one tick and returns the result beat it yields.
  function automatic dim_result_t advance_dimming(logic btn, logic [DataW-1:0] knob,
                                                  logic [DataW-1:0] light);
    dim_result_t res;
    int unsigned sum;
    int unsigned duty;
    int unsigned back;
    logic        tgl;
    tgl = 1'b0;
    // A release inside the short press window flips the backlight.
    if (!btn && press_cnt >= dim_cfg.short_press_min &&
        press_cnt < dim_cfg.long_press_count) begin
      backlight_en = !backlight_en;
    end
    // Sitting at the long press count flips auto mode, button level aside.
    if (press_cnt == dim_cfg.long_press_count) begin
      auto_en = !auto_en;
      tgl = 1'b1;
    end
    if (btn) begin
      if (press_cnt != DutyMax) press_cnt++;
    end else begin
      press_cnt = '0;
    end
    // Input filters.
    sum = knob_filt;
    sum = sum - (sum >> 4) + (32'(knob) << 4);
    knob_filt = sum[FiltW-1:0];
    sum = light_filt;
    sum = sum - (sum >> 8) + 32'(light);
    light_filt = sum[FiltW-1:0];
    // Duty selection with floor and, in auto mode, the ceiling.
    if (auto_en) begin
      duty = (32'(light_filt >> 8) * 32'(knob_filt >> 8)) >> ProdShift;
      if (duty < dim_cfg.min_brightness) duty = dim_cfg.min_brightness;
      else if (duty > DutyMax) duty = DutyMax;
    end else begin
      duty = 32'(knob_filt >> 8);
      if (duty < dim_cfg.min_brightness) duty = dim_cfg.min_brightness;
    end
    back = backlight_en ? duty : 0;
    bl_smooth  = smooth_step(bl_smooth, back);
    dim_smooth = smooth_step(dim_smooth, duty);
    res.duty     = dim_smooth[FiltW-1:8];
    res.bl_cmp   = DutyMax - bl_smooth[FiltW-1:8];
    res.bl_on    = backlight_en;
    res.auto_on  = auto_en;
    res.auto_tgl = tgl;
    return res;
  endfunction

  // Hold length of one press, spread around the short and long press limits.
  function automatic int unsigned pick_hold();
    int unsigned s;
    int unsigned l;
    int unsigned h;
    s = dim_cfg.short_press_min;
    l = dim_cfg.long_press_count;
    case ($urandom_range(5))
      0: h = (s == 0) ? 0 : $urandom_range(s - 1);
      1, 2: h = (l > s) ? s + $urandom_range((l - 1 - s > 20) ? 20 : l - 1 - s) : s;
      3: h = l;
      4: h = l + $urandom_range(1, 4);
      default: h = $urandom_range(300);
    endcase
    return h;
  endfunction

  function automatic logic [DataW-1:0] pick_level();
    case ($urandom_range(2))
      0: return '0;
      1: return DutyMax;
      default: return DataW'($urandom_range(255));
    endcase
  endfunction

  task automatic report_field(string fname, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      $error("mismatch on %s: expected %0d, actual %0d", fname, want, got);
      err_cnt++;
    end
  endtask

  // Drives one input beat, waits for it to be taken and records its result.
  task automatic send_tick(logic btn, logic [DataW-1:0] knob, logic [DataW-1:0] light,
                           logic typed, dim_result_t typed_res);
    dim_result_t res;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    button_pressed_i <= btn;
    knob_sample_i    <= knob;
    light_sample_i   <= light;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    res = advance_dimming(btn, knob, light);
    tick_results_q.push_back(typed ? typed_res : res);
  endtask

  // Slowly wandering sample levels with occasional jumps, so the filters reach their ends.
  task automatic random_tick(logic btn);
    if ($urandom_range(31) == 0) knob_lvl = pick_level();
    if ($urandom_range(31) == 0) light_lvl = pick_level();
    send_tick(btn,
              ($urandom_range(3) == 0) ? DataW'($urandom_range(255)) : knob_lvl,
              ($urandom_range(3) == 0) ? DataW'($urandom_range(255)) : light_lvl,
              1'b0, '0);
  endtask

  // Mostly full press and release sequences, with bursts of random button noise.
  task automatic run_random(int unsigned n, int unsigned pause_at);
    int unsigned sent;
    int unsigned hold;
    int unsigned span;
    logic        paused;
    sent = 0;
    paused = 1'b0;
    while (sent < n) begin
      if ($urandom_range(4) == 0) begin
        span = $urandom_range(1, 8);
        repeat (span) random_tick(1'($urandom_range(1)));
        sent += span;
      end else begin
        hold = pick_hold();
        // Keep the phase close to its beat count.
        if (hold > n - sent) hold = n - sent;
        span = $urandom_range(1, 3);
        repeat (hold) random_tick(1'b1);
        repeat (span) random_tick(1'b0);
        sent += hold + span;
      end
      // Hold the sender off until the block has delivered everything.
      if (pause_at != 0 && !paused && sent >= pause_at) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
    end
  endtask

  // Stops sending and lets the block run empty.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all three registers and one unmapped index, one beat per cycle.
  task automatic load_config(badc_cfg_t cfg);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegShortPressMin;
    cfg_data_i <= cfg.short_press_min;
    @(posedge clk_i);
    cfg_idx_i  <= RegLongPressCount;
    cfg_data_i <= cfg.long_press_count;
    @(posedge clk_i);
    cfg_idx_i  <= RegMinBrightness;
    cfg_data_i <= cfg.min_brightness;
    @(posedge clk_i);
    cfg_idx_i  <= RegSpare;
    cfg_data_i <= DataW'($urandom_range(255));
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    dim_cfg = cfg;
  endtask

  task automatic run_phase(badc_cfg_t cfg, int unsigned tx_pct, int unsigned rx_pct,
                           int unsigned n, int unsigned pause_at);
    settle_idle();
    load_config(cfg);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    run_random(n, pause_at);
  endtask

  // Result side: check each beat taken, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (tick_results_q.size() == 0) begin
        $error("result beat arrived with no tick pending");
        err_cnt++;
      end else begin
        head_result = tick_results_q.pop_front();
        report_field("dimming_duty", head_result.duty, dimming_duty_o);
        report_field("backlight_compare", head_result.bl_cmp, backlight_compare_o);
        report_field("backlight_on", DataW'(head_result.bl_on), DataW'(backlight_on_o));
        report_field("auto_on", DataW'(head_result.auto_on), DataW'(auto_on_o));
        report_field("auto_toggled", DataW'(head_result.auto_tgl), DataW'(auto_toggled_o));
      end
    end
    out_stall_i <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
  end

  // Stimulus sequence.
  initial begin
    badc_cfg_t rand_cfg;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset register values, then random ticks.
    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].btn, dir_rows[i].knob, dir_rows[i].light,
                dir_rows[i].typed, dir_rows[i].res);
    end
    run_random(250, 0);

    // Smallest limits: the short press window is empty, a hold of one tick flips auto mode, no floor on the duty.
    run_phase('{8'd1, 8'd1, 8'd0}, 83, 0, 200, 0);
    // Largest limits and the highest floor; the sender also waits for a full drain.
    run_phase('{8'd255, 8'd254, 8'd255}, 0, 83, 300, 150);
    // Long press count of zero: auto mode flips on every tick that starts idle.
    run_phase('{8'd0, 8'd0, 8'd128}, 37, 37, 150, 0);
    // Long press count of 255: auto mode flips on every tick of a saturated hold.
    run_phase('{8'd3, 8'd255, 8'd30}, 0, 0, 400, 0);
    // Short press minimum of zero: an idle release toggles the backlight.
    run_phase('{8'd0, 8'd10, 8'd60}, 37, 37, 300, 0);

    // Two phases with random registers and short press windows.
    rand_cfg.long_press_count = DataW'($urandom_range(1, 40));
    rand_cfg.short_press_min  = DataW'($urandom_range(1, rand_cfg.long_press_count));
    rand_cfg.min_brightness   = DataW'($urandom_range(255));
    run_phase(rand_cfg, 83, 0, 200, 0);
    rand_cfg.long_press_count = DataW'($urandom_range(1, 40));
    rand_cfg.short_press_min  = DataW'($urandom_range(1, rand_cfg.long_press_count));
    rand_cfg.min_brightness   = DataW'($urandom_range(255));
    run_phase(rand_cfg, 0, 83, 150, 0);

    settle_idle();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/badc_pkg.sv
design/badc_press.sv
design/badc_duty.sv
design/button_and_auto_dimming_control.sv
tb/tb_top.sv
